// ===== rtl/tpu_pkg.sv =====
// ----------------------------------------------------------------------------
// tpu_pkg
// Shared types and constants for the tile predictor undo raster writer.
// ----------------------------------------------------------------------------
package tpu_pkg;

    localparam int DIM_BITS_DEF = 16;
    localparam int SAMPLE_W     = 32;
    localparam int HALF_W       = 16;
    localparam int IDX_W        = 32;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_TILE_WIDTH   = 3'd2,
        REG_TILE_HEIGHT  = 3'd3,
        REG_WIDE_SAMPLES = 3'd4,
        REG_PREDICTOR_ON = 3'd5,
        REG_BIG_ENDIAN   = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic wide;
        logic pred;
        logic big_endian;
    } t_fmt;

    typedef struct packed {
        logic             in_image;
        logic             first_col;
        logic             last;
        logic [IDX_W-1:0] pixel_index;
    } t_pos;

endpackage

// ===== rtl/tpu_if.sv =====
// ----------------------------------------------------------------------------
// tpu_if
// Channel interfaces: sample input, pixel output and configuration writes.
// ----------------------------------------------------------------------------
interface tpu_sample_if import tpu_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_bytes;

    modport source (output valid, output sample_bytes, input ready);
    modport sink   (input valid, input sample_bytes, output ready);
endinterface

interface tpu_pixel_if import tpu_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    pixel_index;
    logic [SAMPLE_W-1:0] pixel_value;
    logic                image_done;

    modport source (output valid, output pixel_index, output pixel_value,
                    output image_done, input ready);
    modport sink   (input valid, input pixel_index, input pixel_value,
                    input image_done, output ready);
endinterface

interface tpu_cfg_if import tpu_pkg::*; #(
    parameter int DATA_W = DIM_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tpu_raster_addr.sv =====
// ----------------------------------------------------------------------------
// tpu_raster_addr
// Tile walk counters: position inside the tile, tile origin and raster row
// base; flags samples inside the image and forms the raster pixel index.
// ----------------------------------------------------------------------------
module tpu_raster_addr import tpu_pkg::*; #(
    parameter int DIM_BITS = DIM_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [DIM_BITS-1:0] i_image_width,
    input  logic [DIM_BITS-1:0] i_image_height,
    input  logic [DIM_BITS-1:0] i_tile_width,
    input  logic [DIM_BITS-1:0] i_tile_height,
    output t_pos                o_pos
);

    localparam int W1 = DIM_BITS + 1;

    logic [DIM_BITS-1:0] r_col, r_row, r_left, r_top;
    logic [DIM_BITS-1:0] n_col, n_row, n_left, n_top;
    logic [IDX_W-1:0]    r_row_start, n_row_start;
    logic [DIM_BITS-1:0] w_tw, w_th;
    logic [W1-1:0]       w_col_abs, w_row_abs;

    always_comb begin
        w_tw = (i_tile_width == '0)  ? DIM_BITS'(1) : i_tile_width;
        w_th = (i_tile_height == '0) ? DIM_BITS'(1) : i_tile_height;

        w_col_abs = W1'(r_left) + W1'(r_col);
        w_row_abs = W1'(r_top) + W1'(r_row);

        o_pos.in_image    = (w_col_abs < W1'(i_image_width)) &&
                            (w_row_abs < W1'(i_image_height));
        o_pos.first_col   = (r_col == '0);
        o_pos.last        = (w_col_abs + W1'(1) == W1'(i_image_width)) &&
                            (w_row_abs + W1'(1) == W1'(i_image_height));
        o_pos.pixel_index = r_row_start + IDX_W'(w_col_abs);
    end

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_left      = r_left;
        n_top       = r_top;
        n_row_start = r_row_start;
        if (i_advance) begin
            if (W1'(r_col) + W1'(1) < W1'(w_tw)) begin
                n_col = r_col + DIM_BITS'(1);
            end else begin
                n_col = '0;
                if (W1'(r_row) + W1'(1) < W1'(w_th)) begin
                    n_row       = r_row + DIM_BITS'(1);
                    n_row_start = r_row_start + IDX_W'(i_image_width);
                end else begin
                    n_row = '0;
                    if (W1'(r_left) + W1'(w_tw) < W1'(i_image_width)) begin
                        n_left = r_left + w_tw;
                    end else begin
                        n_left = '0;
                        if (W1'(r_top) + W1'(w_th) < W1'(i_image_height)) begin
                            n_top = r_top + w_th;
                        end else begin
                            n_top = '0;
                        end
                    end
                    n_row_start = IDX_W'(n_top) * IDX_W'(i_image_width);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= '0;
            r_top       <= '0;
            r_row_start <= '0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_left      <= n_left;
            r_top       <= n_top;
            r_row_start <= n_row_start;
        end
    end

endmodule

// ===== rtl/tpu_value.sv =====
// ----------------------------------------------------------------------------
// tpu_value
// Sample assembly in the configured byte order and predictor undo by a
// running sum that restarts at each tile row.
// ----------------------------------------------------------------------------
module tpu_value import tpu_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [SAMPLE_W-1:0] i_raw,
    input  t_fmt                i_fmt,
    input  t_pos                i_pos,
    output logic [SAMPLE_W-1:0] o_value
);

    logic [SAMPLE_W-1:0] r_sum, n_sum;
    logic [SAMPLE_W-1:0] w_sample, w_base, w_total;

    always_comb begin
        if (i_fmt.wide && i_fmt.big_endian) begin
            w_sample = {i_raw[7:0], i_raw[15:8], i_raw[23:16], i_raw[31:24]};
        end else if (i_fmt.wide) begin
            w_sample = i_raw;
        end else if (i_fmt.big_endian) begin
            w_sample = {{HALF_W{1'b0}}, i_raw[7:0], i_raw[15:8]};
        end else begin
            w_sample = {{HALF_W{1'b0}}, i_raw[HALF_W-1:0]};
        end

        w_base  = i_pos.first_col ? '0 : r_sum;
        w_total = w_base + w_sample;
        o_value = i_fmt.wide ? w_total : {{HALF_W{1'b0}}, w_total[HALF_W-1:0]};

        n_sum = r_sum;
        if (i_advance) begin
            if (i_pos.in_image) begin
                n_sum = i_fmt.pred ? o_value : '0;
            end else begin
                n_sum = w_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

endmodule

// ===== rtl/tile_predictor_undo_raster_writer.sv =====
// ----------------------------------------------------------------------------
// tile_predictor_undo_raster_writer
// Takes tile samples in tile order, undoes the horizontal predictor and
// emits raster pixel index and value; padding samples give no pixel.
// Path: a transferred sample is held in the input register, then its pixel goes to the result register.
// Throughput: one sample per cycle while the pixel output is not stalled, set by the input and result registers.
// The tile counters and running sum update once for each sample that moves.
// Reset: counters, running sum and valids clear; sizes go to 1, flags to 0.
// ----------------------------------------------------------------------------
module tile_predictor_undo_raster_writer import tpu_pkg::*; #(
    parameter int DIM_BITS = DIM_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpu_cfg_if.sink     i_cfg,
    tpu_sample_if.sink  i_sample,
    tpu_pixel_if.source o_pixel
);

    logic [DIM_BITS-1:0] r_image_width, r_image_height, r_tile_width, r_tile_height;
    t_fmt                r_fmt;

    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_bytes;

    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_index;
    logic [SAMPLE_W-1:0] r_out_value;
    logic                r_out_done;

    logic                w_move;
    t_pos                w_pos;
    logic [SAMPLE_W-1:0] w_value;

    assign i_cfg.ready    = 1'b1;
    assign w_move         = r_in_valid && (!r_out_valid || o_pixel.ready);
    assign i_sample.ready = !r_in_valid || w_move;

    assign o_pixel.valid       = r_out_valid;
    assign o_pixel.pixel_index = r_out_index;
    assign o_pixel.pixel_value = r_out_value;
    assign o_pixel.image_done  = r_out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_BITS'(1);
            r_image_height <= DIM_BITS'(1);
            r_tile_width   <= DIM_BITS'(1);
            r_tile_height  <= DIM_BITS'(1);
            r_fmt          <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg.data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg.data;
                REG_TILE_WIDTH:   r_tile_width   <= i_cfg.data;
                REG_TILE_HEIGHT:  r_tile_height  <= i_cfg.data;
                REG_WIDE_SAMPLES: r_fmt.wide       <= i_cfg.data[0];
                REG_PREDICTOR_ON: r_fmt.pred       <= i_cfg.data[0];
                REG_BIG_ENDIAN:   r_fmt.big_endian <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in_bytes <= i_sample.sample_bytes;
        end
    end

    tpu_raster_addr #(
        .DIM_BITS (DIM_BITS)
    ) u_addr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_move),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_tile_width   (r_tile_width),
        .i_tile_height  (r_tile_height),
        .o_pos          (w_pos)
    );

    tpu_value u_value (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_move),
        .i_raw     (r_in_bytes),
        .i_fmt     (r_fmt),
        .i_pos     (w_pos),
        .o_value   (w_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= w_pos.in_image;
        end else if (o_pixel.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move && w_pos.in_image) begin
            r_out_index <= w_pos.pixel_index;
            r_out_value <= w_value;
            r_out_done  <= w_pos.last;
        end
    end

    a_pixel_follows_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move && w_pos.in_image |=> o_pixel.valid)
        else $error("pixel lost after an in-image sample moved");

    a_padding_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move && !w_pos.in_image |=> !o_pixel.valid)
        else $error("pixel produced for a padding sample");

    a_stalled_input_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_move |=> r_in_valid && $stable(r_in_bytes))
        else $error("input register changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pixel.valid && !r_in_valid)
        else $error("valids not cleared by reset");

endmodule

// ===== bench/tpu_raster_pkg.sv =====
// ----------------------------------------------------------------------------
// tpu_raster_pkg
// Scoreboard for the raster writer bench: tracks the tile position, the
// byte order and the running sum, and queues the pixels each sample yields.
// ----------------------------------------------------------------------------
package tpu_raster_pkg;
    import tpu_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]    index;
        logic [SAMPLE_W-1:0] value;
        logic                done;
    } pixel_t;

    typedef struct packed {
        logic [15:0]      col_in_tile;
        logic [15:0]      row_in_tile;
        logic [15:0]      tile_left;
        logic [15:0]      tile_top;
        logic [IDX_W-1:0] row_start;
    } tile_pos_t;

    class raster_tracker;
        logic [15:0]         img_w;
        logic [15:0]         img_h;
        logic [15:0]         tile_w;
        logic [15:0]         tile_h;
        logic                wide;
        logic                pred;
        logic                big_end;
        tile_pos_t           pos;
        logic [SAMPLE_W-1:0] run_sum;
        pixel_t              pending_pixels[$];
        int                  errors;

        function new();
            img_w   = 16'd1;
            img_h   = 16'd1;
            tile_w  = 16'd1;
            tile_h  = 16'd1;
            wide    = 1'b0;
            pred    = 1'b0;
            big_end = 1'b0;
            pos     = '0;
            run_sum = '0;
            errors  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
            case (idx)
                REG_IMAGE_WIDTH:  img_w   = value;
                REG_IMAGE_HEIGHT: img_h   = value;
                REG_TILE_WIDTH:   tile_w  = value;
                REG_TILE_HEIGHT:  tile_h  = value;
                REG_WIDE_SAMPLES: wide    = value[0];
                REG_PREDICTOR_ON: pred    = value[0];
                REG_BIG_ENDIAN:   big_end = value[0];
                default: ;
            endcase
        endfunction

        function logic [SAMPLE_W-1:0] assemble(logic [SAMPLE_W-1:0] raw);
            if (wide)
                return big_end ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
            return big_end ? {16'h0, raw[7:0], raw[15:8]} : {16'h0, raw[15:0]};
        endfunction

        function tile_pos_t next_pos(tile_pos_t p);
            logic [16:0] tw;
            logic [16:0] th;
            tw = (tile_w == 16'd0) ? 17'd1 : {1'b0, tile_w};
            th = (tile_h == 16'd0) ? 17'd1 : {1'b0, tile_h};
            if ({1'b0, p.col_in_tile} + 17'd1 < tw) begin
                p.col_in_tile = p.col_in_tile + 16'd1;
                return p;
            end
            p.col_in_tile = '0;
            if ({1'b0, p.row_in_tile} + 17'd1 < th) begin
                p.row_in_tile = p.row_in_tile + 16'd1;
                p.row_start   = p.row_start + {16'h0, img_w};
                return p;
            end
            p.row_in_tile = '0;
            if ({1'b0, p.tile_left} + tw < {1'b0, img_w}) begin
                p.tile_left = p.tile_left + tw[15:0];
            end else begin
                p.tile_left = '0;
                if ({1'b0, p.tile_top} + th < {1'b0, img_h})
                    p.tile_top = p.tile_top + th[15:0];
                else
                    p.tile_top = '0;
            end
            p.row_start = {16'h0, p.tile_top} * {16'h0, img_w};
            return p;
        endfunction

        function int steps_to_origin(int cap);
            tile_pos_t p;
            int        n;
            p = pos;
            n = 0;
            do begin
                p = next_pos(p);
                n++;
            end while ((p.col_in_tile | p.row_in_tile | p.tile_left | p.tile_top) != 16'd0
                       && n < cap);
            return n;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] raw);
            logic [SAMPLE_W-1:0] smp;
            logic [SAMPLE_W-1:0] vmask;
            logic [SAMPLE_W-1:0] val;
            logic [16:0]         col;
            logic [16:0]         row;
            pixel_t              px;
            smp   = assemble(raw);
            vmask = wide ? 32'hFFFF_FFFF : 32'h0000_FFFF;
            col   = {1'b0, pos.tile_left} + {1'b0, pos.col_in_tile};
            row   = {1'b0, pos.tile_top} + {1'b0, pos.row_in_tile};
            if (pos.col_in_tile == 16'd0)
                run_sum = '0;
            if (col < {1'b0, img_w} && row < {1'b0, img_h}) begin
                val      = (run_sum + smp) & vmask;
                run_sum  = pred ? val : '0;
                px.index = pos.row_start + {15'h0, col};
                px.value = val;
                px.done  = (col + 17'd1 == {1'b0, img_w}) && (row + 17'd1 == {1'b0, img_h});
                pending_pixels.push_back(px);
            end
            pos = next_pos(pos);
        endfunction

        function void check_pixel(logic [IDX_W-1:0] index, logic [SAMPLE_W-1:0] value,
                                  logic done);
            pixel_t want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, got index %0h value %0h done %0b",
                         $time, index, value, done);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (index !== want.index) begin
                $display("%0t: pixel_index expected %0h got %0h", $time, want.index, index);
                errors++;
            end
            if (value !== want.value) begin
                $display("%0t: pixel_value expected %0h got %0h", $time, want.value, value);
                errors++;
            end
            if (done !== want.done) begin
                $display("%0t: image_done expected %0b got %0b", $time, want.done, done);
                errors++;
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

endpackage

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives tile samples and register writes into the raster writer with random
// gaps and output stalls, and checks every pixel against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;
    import tpu_pkg::*;
    import tpu_raster_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam int RANDOM_SAMPLES = 1600;
    localparam int ORIGIN_CAP     = 300;

    logic          i_clk;
    logic          i_rst_n;
    raster_tracker tracker;
    int            samples_sent;
    bit            no_idle;
    int            full;
    int            n;

    tpu_cfg_if #(.DATA_W(16)) cfg_bus();
    tpu_sample_if             sample_bus();
    tpu_pixel_if              pixel_bus();

    tile_predictor_undo_raster_writer u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_sample (sample_bus),
        .o_pixel  (pixel_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        pixel_bus.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            int stall;
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                pixel_bus.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pixel_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!(pixel_bus.valid && pixel_bus.ready)) @(posedge i_clk);
            tracker.check_pixel(pixel_bus.pixel_index, pixel_bus.pixel_value,
                                pixel_bus.image_done);
            @(negedge i_clk);
        end
    end

    function automatic logic [15:0] draw_size(int hi);
        int r;
        r = $urandom_range(0, 31);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r == 2) return 16'($urandom_range(1, 65535));
        return 16'($urandom_range(1, hi));
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        tracker.set_reg(idx, value);
        @(negedge i_clk);
    endtask

    task automatic apply_config(logic [15:0] w, logic [15:0] h, logic [15:0] tw,
                                logic [15:0] th, bit wide, bit pred, bit be);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_TILE_WIDTH, tw);
        write_reg(REG_TILE_HEIGHT, th);
        write_reg(REG_WIDE_SAMPLES, {15'($urandom_range(0, 32767)), wide});
        write_reg(REG_PREDICTOR_ON, {15'($urandom_range(0, 32767)), pred});
        write_reg(REG_BIG_ENDIAN, {15'($urandom_range(0, 32767)), be});
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_NONE, 16'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_sample(logic [SAMPLE_W-1:0] value, int gap);
        if (gap > 0) begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_bus.valid        <= 1'b1;
        sample_bus.sample_bytes <= value;
        @(posedge i_clk);
        while (!sample_bus.ready) @(posedge i_clk);
        tracker.note_sample(value);
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_samples(int count);
        for (int i = 0; i < count; i++)
            send_sample(draw_sample(), no_idle ? 0 : $urandom_range(0, 7));
        sample_bus.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [15:0] w, logic [15:0] h, logic [15:0] tw,
                             logic [15:0] th, bit wide, bit pred, bit be, int count);
        wait_drained();
        apply_config(w, h, tw, th, wide, pred, be);
        send_samples(count);
    endtask

    initial begin
        tracker                 = new();
        samples_sent            = 0;
        no_idle                 = 1'b0;
        i_rst_n                 = 1'b0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.index           = REG_IMAGE_WIDTH;
        cfg_bus.data            = '0;
        sample_bus.valid        = 1'b0;
        sample_bus.sample_bytes = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_sample(32'h0000_0000, 0);
        send_sample(32'hFFFF_FFFF, 2);
        sample_bus.valid <= 1'b0;
        run_phase(16'd3, 16'd1, 16'd2, 16'd2, 1'b0, 1'b1, 1'b0, 8);
        run_phase(16'd2, 16'd2, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 3);
        run_phase(16'd3, 16'd2, 16'd3, 16'd1, 1'b0, 1'b0, 1'b1, 3);
        run_phase(16'd0, 16'd5, 16'd2, 16'd2, 1'b1, 1'b1, 1'b0, 3);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 4);

        while (samples_sent < RANDOM_SAMPLES + 23) begin
            no_idle = ($urandom_range(0, 3) == 0);
            wait_drained();
            apply_config(draw_size(12), draw_size(12), draw_size(6), draw_size(6),
                         1'($urandom), 1'($urandom), 1'($urandom));
            full = tracker.steps_to_origin(ORIGIN_CAP);
            if (full >= ORIGIN_CAP || $urandom_range(0, 4) == 0)
                n = $urandom_range(1, 30);
            else
                n = full;
            send_samples(n);
        end

        wait_drained();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
